[design/plsn_pkg.sv]
package plsn_pkg;

    // Fixed field widths of the channels.
    localparam int FUNC_W     = 2;
    localparam int NODE_IDX_W = 10;
    localparam int ITER_W     = 12;
    localparam int DAMP_W     = 16;
    localparam int TOL_W      = 32;
    localparam int SCORE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default capacities.
    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 8192;

    // Register reset values.
    localparam logic [DAMP_W-1:0] DAMP_RESET  = 16'd55706;
    localparam logic [TOL_W-1:0]  TOL_RESET   = 32'd1;
    localparam logic [ITER_W-1:0] ITER_RESET  = 12'd1000;

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_NODE  = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_START = 2'd2
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAMPING    = 2'd0,
        CFG_TOLERANCE  = 2'd1,
        CFG_ITER_LIMIT = 2'd2
    } cfg_idx_t;

endpackage

[design/plsn_cmd_if.sv]
interface plsn_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [plsn_pkg::FUNC_W-1:0]      func;
    logic                             node_active;
    logic [plsn_pkg::NODE_IDX_W-1:0]  neighbor_index;

    modport source (output valid, func, node_active, neighbor_index, input ready);
    modport sink (input valid, func, node_active, neighbor_index, output ready);
endinterface

[design/plsn_res_if.sv]
interface plsn_res_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [plsn_pkg::NODE_IDX_W-1:0]  best_node;
    logic [plsn_pkg::ITER_W-1:0]      iterations_run;
    logic                             capacity_overflow;

    modport source (output valid, found, best_node, iterations_run, capacity_overflow,
                    input ready);
    modport sink (input valid, found, best_node, iterations_run, capacity_overflow,
                  output ready);
endinterface

[design/plsn_cfg_if.sv]
interface plsn_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [plsn_pkg::CFG_IDX_W-1:0]   index;
    logic [plsn_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/plsn_ram.sv]
module plsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds without a read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/pagerank_least_score_node.sv]
// Load items (node, edge, unknown) are accepted back to back while the block is idle. A start
// item uses one shared restoring divider and one shared multiplier: it counts the active nodes,
// runs two divisions, initializes the scores, then per iteration scatters the shares with one
// division per active node with edges and one for the dangling share and updates the scores,
// and last searches for the least score. The result waits in an output register while load items
// go on. Reset (rst_n, asynchronous, active low) empties the graph and the config and control registers.
module pagerank_least_score_node #(
    parameter int MAX_NODES = plsn_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = plsn_pkg::MAX_EDGES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    plsn_cfg_if.sink  cfg,
    plsn_cmd_if.sink  cmd,
    plsn_res_if.source res
);

    localparam int NA_W   = $clog2(MAX_NODES);
    localparam int EA_W   = $clog2(MAX_EDGES);
    localparam int NC_W   = $clog2(MAX_NODES + 1);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int CNT_W  = (NC_W > EC_W) ? NC_W : EC_W;
    localparam int SW     = plsn_pkg::SCORE_W;
    localparam int ACC_W  = SW + CNT_W;
    localparam int PROD_W = ACC_W + plsn_pkg::DAMP_W;
    localparam int NI_W   = 1 + 2 * EC_W;
    localparam int DC_W   = $clog2(ACC_W);
    localparam logic [SW-1:0] SMAX = '1;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_CNT_A  = 20'h00002,
        S_CNT_B  = 20'h00004,
        S_DIV    = 20'h00008,
        S_TELE   = 20'h00010,
        S_INIT   = 20'h00020,
        S_ITER   = 20'h00040,
        S_CLR    = 20'h00080,
        S_SCAN_A = 20'h00100,
        S_SCAN_B = 20'h00200,
        S_EDGE_A = 20'h00400,
        S_EDGE_B = 20'h00800,
        S_EDGE_C = 20'h01000,
        S_DSH_M  = 20'h02000,
        S_DSH_D  = 20'h04000,
        S_UPD_A  = 20'h08000,
        S_UPD_B  = 20'h10000,
        S_UPD_C  = 20'h20000,
        S_MIN_A  = 20'h40000,
        S_FIN    = 20'h80000
    } state_t;

    // Registers.
    state_t                        state_reg, state_next, ret_reg, ret_next;
    logic [plsn_pkg::DAMP_W-1:0]   damp_reg;
    logic [plsn_pkg::TOL_W-1:0]    tol_reg;
    logic [plsn_pkg::ITER_W-1:0]   limit_reg;
    logic [NC_W-1:0]               node_cnt_reg, node_cnt_next;
    logic [EC_W-1:0]               edge_cnt_reg, edge_cnt_next;
    logic                          ovf_reg, ovf_next;
    logic                          cur_valid_reg, cur_valid_next;
    logic                          cur_act_reg, cur_act_next;
    logic [EC_W-1:0]               cur_row_reg, cur_row_next;
    logic [EC_W-1:0]               cur_deg_reg, cur_deg_next;
    logic [NC_W-1:0]               i_reg, i_next;
    logic [NC_W-1:0]               act_cnt_reg, act_cnt_next;
    logic [EC_W-1:0]               e_reg, e_next;
    logic [EC_W-1:0]               k_reg, k_next;
    logic [EC_W-1:0]               deg_reg, deg_next;
    logic [NA_W-1:0]               v_reg, v_next;
    logic [SW-1:0]                 init_reg, init_next;
    logic [ACC_W-1:0]              tele_reg, tele_next;
    logic [ACC_W-1:0]              dang_reg, dang_next;
    logic [ACC_W-1:0]              diff_reg, diff_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [ACC_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              dvs_reg, dvs_next;
    logic [DC_W-1:0]               dcnt_reg, dcnt_next;
    logic [plsn_pkg::ITER_W-1:0]   iters_reg, iters_next;
    logic                          have_reg, have_next;
    logic [NA_W-1:0]               best_reg, best_next;
    logic [SW-1:0]                 bestv_reg, bestv_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg, out_found_next;
    logic [plsn_pkg::NODE_IDX_W-1:0] out_best_reg, out_best_next;
    logic [plsn_pkg::ITER_W-1:0]   out_iters_reg, out_iters_next;
    logic                          out_ovf_reg, out_ovf_next;

    // Memory ports.
    logic                 node_we, node_re, edge_we, edge_re;
    logic                 score_we, score_re, nxt_we, nxt_re;
    logic [NA_W-1:0]      node_waddr, node_raddr, score_waddr, score_raddr;
    logic [NA_W-1:0]      nxt_waddr, nxt_raddr;
    logic [EA_W-1:0]      edge_waddr, edge_raddr;
    logic [NI_W-1:0]      node_wdata, node_rdata;
    logic [plsn_pkg::NODE_IDX_W-1:0] edge_wdata, edge_rdata;
    logic [SW-1:0]        score_wdata, score_rdata;
    logic [ACC_W-1:0]     nxt_wdata, nxt_rdata;

    // Combinational helpers.
    logic                 cmd_fire, cfg_fire, rd_act, last_i, last_k;
    logic [EC_W-1:0]      rd_row, rd_deg;
    logic [CNT_W:0]       trial;
    logic [ACC_W+1:0]     upd_sum;
    logic [SW-1:0]        upd_val, abs_diff;
    logic [ACC_W-1:0]     diff_sum, diff_now;
    logic [ACC_W-1:0]     mul_a;
    logic [31:0]          v_wide;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid             = out_valid_reg;
    assign res.found             = out_found_reg;
    assign res.best_node         = out_best_reg;
    assign res.iterations_run    = out_iters_reg;
    assign res.capacity_overflow = out_ovf_reg;

    assign rd_act = node_rdata[NI_W-1];
    assign rd_row = node_rdata[2*EC_W-1:EC_W];
    assign rd_deg = node_rdata[EC_W-1:0];
    assign last_i = (i_reg + NC_W'(1)) == node_cnt_reg;
    assign last_k = (k_reg + EC_W'(1)) == deg_reg;
    assign v_wide = 32'(edge_rdata);

    // Divider trial subtraction, one quotient bit per cycle.
    assign trial = {rem_reg, quo_reg[ACC_W-1]} - {1'b0, dvs_reg};

    // Score update: damped inflow plus dangling share plus teleport, saturated.
    assign upd_sum  = (ACC_W+2)'(prod_reg[PROD_W-1:plsn_pkg::DAMP_W])
                    + (ACC_W+2)'(quo_reg) + (ACC_W+2)'(tele_reg);
    assign upd_val  = (upd_sum > (ACC_W+2)'(SMAX)) ? SMAX : upd_sum[SW-1:0];
    assign abs_diff = (upd_val >= score_rdata) ? (upd_val - score_rdata)
                                               : (score_rdata - upd_val);
    assign diff_sum = diff_reg + ACC_W'(abs_diff);
    assign diff_now = (state_reg == S_UPD_C) ? diff_sum : diff_reg;

    // Shared multiplier operand.
    assign mul_a = (state_reg == S_DSH_M) ? dang_reg : nxt_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_reg  <= plsn_pkg::DAMP_RESET;
            tol_reg   <= plsn_pkg::TOL_RESET;
            limit_reg <= plsn_pkg::ITER_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (plsn_pkg::cfg_idx_t'(cfg.index))
                plsn_pkg::CFG_DAMPING:    damp_reg  <= cfg.data[plsn_pkg::DAMP_W-1:0];
                plsn_pkg::CFG_TOLERANCE:  tol_reg   <= cfg.data[plsn_pkg::TOL_W-1:0];
                plsn_pkg::CFG_ITER_LIMIT: limit_reg <= cfg.data[plsn_pkg::ITER_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        node_cnt_next  = node_cnt_reg;
        edge_cnt_next  = edge_cnt_reg;
        ovf_next       = ovf_reg;
        cur_valid_next = cur_valid_reg;
        cur_act_next   = cur_act_reg;
        cur_row_next   = cur_row_reg;
        cur_deg_next   = cur_deg_reg;
        i_next         = i_reg;
        act_cnt_next   = act_cnt_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        deg_next       = deg_reg;
        v_next         = v_reg;
        init_next      = init_reg;
        tele_next      = tele_reg;
        dang_next      = dang_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        dcnt_next      = dcnt_reg;
        iters_next     = iters_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        bestv_next     = bestv_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_found_next = out_found_reg;
        out_best_next  = out_best_reg;
        out_iters_next = out_iters_reg;
        out_ovf_next   = out_ovf_reg;

        node_we = 1'b0; node_re = 1'b0; edge_we = 1'b0; edge_re = 1'b0;
        score_we = 1'b0; score_re = 1'b0; nxt_we = 1'b0; nxt_re = 1'b0;
        node_waddr  = node_cnt_reg[NA_W-1:0];
        node_wdata  = {cmd.node_active, edge_cnt_reg, EC_W'(0)};
        node_raddr  = i_reg[NA_W-1:0];
        edge_waddr  = edge_cnt_reg[EA_W-1:0];
        edge_wdata  = cmd.neighbor_index;
        edge_raddr  = e_reg[EA_W-1:0];
        score_waddr = i_reg[NA_W-1:0];
        score_wdata = init_reg;
        score_raddr = i_reg[NA_W-1:0];
        nxt_waddr   = i_reg[NA_W-1:0];
        nxt_wdata   = '0;
        nxt_raddr   = i_reg[NA_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.func)
                        plsn_pkg::FUNC_NODE:
                        begin
                            if (node_cnt_reg < NC_W'(MAX_NODES))
                            begin
                                node_we        = 1'b1;
                                cur_valid_next = 1'b1;
                                cur_act_next   = cmd.node_active;
                                cur_row_next   = edge_cnt_reg;
                                cur_deg_next   = '0;
                                node_cnt_next  = node_cnt_reg + NC_W'(1);
                            end
                            else
                            begin
                                ovf_next       = 1'b1;
                                cur_valid_next = 1'b0;
                            end
                        end
                        plsn_pkg::FUNC_EDGE:
                        begin
                            if (cur_valid_reg)
                            begin
                                if (edge_cnt_reg < EC_W'(MAX_EDGES))
                                begin
                                    edge_we       = 1'b1;
                                    node_we       = 1'b1;
                                    node_waddr    = NA_W'(node_cnt_reg - NC_W'(1));
                                    node_wdata    = {cur_act_reg, cur_row_reg,
                                                     cur_deg_reg + EC_W'(1)};
                                    cur_deg_next  = cur_deg_reg + EC_W'(1);
                                    edge_cnt_next = edge_cnt_reg + EC_W'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        plsn_pkg::FUNC_START:
                        begin
                            i_next       = '0;
                            act_cnt_next = '0;
                            iters_next   = '0;
                            have_next    = 1'b0;
                            best_next    = '0;
                            state_next   = (node_cnt_reg == '0) ? S_FIN : S_CNT_A;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Count active nodes.
            S_CNT_A:
            begin
                node_re    = 1'b1;
                state_next = S_CNT_B;
            end
            S_CNT_B:
            begin
                act_cnt_next = act_cnt_reg + NC_W'(rd_act);
                i_next       = i_reg + NC_W'(1);
                state_next   = S_CNT_A;
                if (last_i)
                begin
                    if (act_cnt_next == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        quo_next   = ACC_W'(1) << SW;
                        dvs_next   = CNT_W'(act_cnt_next);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        ret_next   = S_TELE;
                        state_next = S_DIV;
                    end
                end
            end

            // Shared restoring divider.
            S_DIV:
            begin
                if (!trial[CNT_W])
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[CNT_W-2:0], quo_reg[ACC_W-1]};
                    quo_next = {quo_reg[ACC_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(ACC_W - 1))
                begin
                    state_next = ret_reg;
                end
            end

            // Initial share, then the teleport term.
            S_TELE:
            begin
                init_next  = (quo_reg > ACC_W'(SMAX)) ? SMAX : quo_reg[SW-1:0];
                quo_next   = ACC_W'({17'h10000 - {1'b0, damp_reg}}) << (SW - 16);
                dvs_next   = CNT_W'(node_cnt_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                i_next     = '0;
                ret_next   = S_INIT;
                state_next = S_DIV;
            end
            S_INIT:
            begin
                tele_next  = quo_reg;
                score_we   = 1'b1;
                i_next     = i_reg + NC_W'(1);
                if (last_i)
                begin
                    state_next = S_ITER;
                end
            end

            // Iteration head and clearing of the inflow sums.
            S_ITER:
            begin
                i_next    = '0;
                dang_next = '0;
                state_next = (iters_reg < limit_reg) ? S_CLR : S_MIN_A;
            end
            S_CLR:
            begin
                nxt_we = 1'b1;
                i_next = i_reg + NC_W'(1);
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = S_SCAN_A;
                end
            end

            // Scatter each active node's share along its edges.
            S_SCAN_A:
            begin
                node_re    = 1'b1;
                score_re   = 1'b1;
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                i_next     = i_reg + NC_W'(1);
                state_next = last_i ? S_DSH_M : S_SCAN_A;
                if (rd_act)
                begin
                    if (rd_deg == '0)
                    begin
                        dang_next = dang_reg + ACC_W'(score_rdata);
                    end
                    else
                    begin
                        i_next     = i_reg;
                        deg_next   = rd_deg;
                        e_next     = rd_row;
                        k_next     = '0;
                        quo_next   = ACC_W'(score_rdata);
                        dvs_next   = CNT_W'(rd_deg);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        ret_next   = S_EDGE_A;
                        state_next = S_DIV;
                    end
                end
            end
            S_EDGE_A:
            begin
                edge_re    = 1'b1;
                state_next = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                if (v_wide < 32'(node_cnt_reg))
                begin
                    v_next     = v_wide[NA_W-1:0];
                    node_re    = 1'b1;
                    node_raddr = v_wide[NA_W-1:0];
                    nxt_re     = 1'b1;
                    nxt_raddr  = v_wide[NA_W-1:0];
                    state_next = S_EDGE_C;
                end
                else
                begin
                    e_next = e_reg + EC_W'(1);
                    k_next = k_reg + EC_W'(1);
                    if (last_k)
                    begin
                        i_next     = i_reg + NC_W'(1);
                        state_next = last_i ? S_DSH_M : S_SCAN_A;
                    end
                    else
                    begin
                        state_next = S_EDGE_A;
                    end
                end
            end
            S_EDGE_C:
            begin
                nxt_we    = rd_act;
                nxt_waddr = v_reg;
                nxt_wdata = nxt_rdata + quo_reg;
                e_next    = e_reg + EC_W'(1);
                k_next    = k_reg + EC_W'(1);
                if (last_k)
                begin
                    i_next     = i_reg + NC_W'(1);
                    state_next = last_i ? S_DSH_M : S_SCAN_A;
                end
                else
                begin
                    state_next = S_EDGE_A;
                end
            end

            // Dangling share: damp, then divide by the node count.
            S_DSH_M:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(damp_reg);
                state_next = S_DSH_D;
            end
            S_DSH_D:
            begin
                quo_next   = prod_reg[PROD_W-1:plsn_pkg::DAMP_W];
                dvs_next   = CNT_W'(node_cnt_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                i_next     = '0;
                diff_next  = '0;
                ret_next   = S_UPD_A;
                state_next = S_DIV;
            end

            // New scores and the summed change.
            S_UPD_A:
            begin
                node_re    = 1'b1;
                score_re   = 1'b1;
                nxt_re     = 1'b1;
                state_next = S_UPD_B;
            end
            S_UPD_B:
            begin
                prod_next = PROD_W'(mul_a) * PROD_W'(damp_reg);
                if (rd_act)
                begin
                    state_next = S_UPD_C;
                end
                else
                begin
                    i_next     = i_reg + NC_W'(1);
                    state_next = S_UPD_A;
                end
            end
            S_UPD_C:
            begin
                score_we    = 1'b1;
                score_wdata = upd_val;
                diff_next   = diff_sum;
                i_next      = i_reg + NC_W'(1);
                state_next  = S_UPD_A;
            end

            // Least-score search.
            S_MIN_A:
            begin
                node_re  = 1'b1;
                score_re = 1'b1;
                state_next = S_FIN;
                ret_next   = S_MIN_A;
            end

            // Finish the least-score search, then hand the result over once the output register is free.
            S_FIN:
            begin
                if (ret_reg == S_MIN_A)
                begin
                    if (rd_act && (!have_reg || (score_rdata < bestv_reg)))
                    begin
                        have_next  = 1'b1;
                        best_next  = i_reg[NA_W-1:0];
                        bestv_next = score_rdata;
                    end
                    i_next = i_reg + NC_W'(1);
                    if (last_i)
                    begin
                        ret_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MIN_A;
                    end
                end
                else if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = have_reg;
                    out_best_next  = plsn_pkg::NODE_IDX_W'(32'(best_reg));
                    out_iters_next = have_reg ? iters_reg : '0;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of an update pass: count the iteration and test convergence.
        if (((state_reg == S_UPD_B) && !rd_act) || (state_reg == S_UPD_C))
        begin
            if (last_i)
            begin
                iters_next = iters_reg + plsn_pkg::ITER_W'(1);
                i_next     = '0;
                if (diff_now < ACC_W'(tol_reg))
                begin
                    ret_next   = S_IDLE;
                    state_next = S_MIN_A;
                end
                else
                begin
                    state_next = S_ITER;
                end
            end
        end
        if ((state_reg == S_ITER) && !(iters_reg < limit_reg))
        begin
            ret_next = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            node_cnt_reg  <= '0;
            edge_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            node_cnt_reg  <= node_cnt_next;
            edge_cnt_reg  <= edge_cnt_next;
            ovf_reg       <= ovf_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_act_reg   <= cur_act_next;
        cur_row_reg   <= cur_row_next;
        cur_deg_reg   <= cur_deg_next;
        i_reg         <= i_next;
        act_cnt_reg   <= act_cnt_next;
        e_reg         <= e_next;
        k_reg         <= k_next;
        deg_reg       <= deg_next;
        v_reg         <= v_next;
        init_reg      <= init_next;
        tele_reg      <= tele_next;
        dang_reg      <= dang_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        dcnt_reg      <= dcnt_next;
        iters_reg     <= iters_next;
        have_reg      <= have_next;
        best_reg      <= best_next;
        bestv_reg     <= bestv_next;
        out_found_reg <= out_found_next;
        out_best_reg  <= out_best_next;
        out_iters_reg <= out_iters_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Node info: active flag, row start and degree.
    plsn_ram #(.WIDTH(NI_W), .DEPTH(MAX_NODES)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
    );

    // Adjacency lists.
    plsn_ram #(.WIDTH(plsn_pkg::NODE_IDX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
    );

    // Current scores.
    plsn_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_score_ram (
        .clk(clk), .we(score_we), .waddr(score_waddr), .wdata(score_wdata),
        .re(score_re), .raddr(score_raddr), .rdata(score_rdata)
    );

    // Inflow sums of the running iteration.
    plsn_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NODES)) u_next_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rdata)
    );

`ifndef SYNTHESIS
    // The divider never runs on a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dvs_reg != '0))
        else $error("division started with zero divisor");

    // A not-found result carries no node and no iterations.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.found) |-> (res.best_node == '0 && res.iterations_run == '0))
        else $error("not-found result with nonzero fields");

    // The iteration count never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.iterations_run <= limit_reg))
        else $error("iteration count above limit");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int NODE_CAP     = plsn_pkg::MAX_NODES_DEF;
    localparam int EDGE_CAP     = plsn_pkg::MAX_EDGES_DEF;
    localparam int SETTLE_CYC   = 32;
    localparam longint CYC_LIMIT = 20_000_000;
    localparam logic [plsn_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [plsn_pkg::FUNC_W-1:0]     func;
        logic                            node_active;
        logic [plsn_pkg::NODE_IDX_W-1:0] neighbor_index;
    } cmd_item_t;

    typedef struct packed {
        logic                            found;
        logic [plsn_pkg::NODE_IDX_W-1:0] best_node;
        logic [plsn_pkg::ITER_W-1:0]     iterations_run;
        logic                            capacity_overflow;
    } rank_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plsn_cfg_if cfg ();
    plsn_cmd_if cmd ();
    plsn_res_if res ();

    pagerank_least_score_node uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always #5 clk = ~clk;

    // Stimulus and expectation stores.
    cmd_item_t    pending_items[$];
    cmd_item_t    held_item;
    rank_result_t expected_ranks[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    longint      cycle_count = 0;

    // Shadow copy of the graph, the scores and the registers.
    logic [plsn_pkg::DAMP_W-1:0] sh_damping;
    logic [plsn_pkg::TOL_W-1:0]  sh_tolerance;
    logic [plsn_pkg::ITER_W-1:0] sh_iter_limit;
    int unsigned       nbr_mem[EDGE_CAP];
    int unsigned       row_first[NODE_CAP];
    int unsigned       row_degree[NODE_CAP];
    bit                node_on[NODE_CAP];
    longint unsigned   rank_now[NODE_CAP];
    longint unsigned   rank_next[NODE_CAP];
    int unsigned       nodes_loaded = 0;
    int unsigned       edges_loaded = 0;
    bit                overflow_flag = 1'b0;
    bit                node_open = 1'b0;

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint unsigned damp_scale(longint unsigned x, int unsigned d);
        return (x >> 16) * d + (((x & 64'hFFFF) * d) >> 16);
    endfunction

    // Power iteration over the shadow graph; returns the least-score active node.
    function automatic rank_result_t rank_least_node();
        rank_result_t    r;
        longint unsigned unit_val, top_val, tele, init, best_val;
        longint unsigned dang, dsh, diff, share, val;
        int unsigned     active_cnt, iters, best, d, n, e, v;
        active_cnt = 0;
        iters = 0;
        best = 0;
        best_val = 64'hFFFF_FFFF_FFFF_FFFF;
        unit_val = 64'd1 << plsn_pkg::SCORE_W;
        top_val = unit_val - 1;
        d = sh_damping;
        n = nodes_loaded;
        for (int i = 0; i < n; i++) active_cnt += node_on[i];
        r.capacity_overflow = overflow_flag;
        r.iterations_run = '0;
        if (active_cnt == 0)
        begin
            r.found = 1'b0;
            r.best_node = '0;
            return r;
        end
        init = unit_val / active_cnt;
        if (init > top_val) init = top_val;
        for (int i = 0; i < n; i++) rank_now[i] = node_on[i] ? init : 0;
        tele = (longint'(65536 - d) << (plsn_pkg::SCORE_W - 16)) / n;
        while (iters < sh_iter_limit)
        begin
            dang = 0;
            diff = 0;
            for (int i = 0; i < NODE_CAP; i++) rank_next[i] = 0;
            for (int i = 0; i < n; i++)
            begin
                if (!node_on[i]) continue;
                if (row_degree[i] == 0)
                begin
                    dang = add_sat(dang, rank_now[i]);
                    continue;
                end
                share = rank_now[i] / row_degree[i];
                for (int k = 0; k < row_degree[i]; k++)
                begin
                    e = row_first[i] + k;
                    if (e >= edges_loaded) break;
                    v = nbr_mem[e];
                    if (v < n && node_on[v]) rank_next[v] = add_sat(rank_next[v], share);
                end
            end
            dsh = damp_scale(dang, d) / n;
            for (int i = 0; i < n; i++)
            begin
                if (!node_on[i]) continue;
                val = add_sat(add_sat(damp_scale(rank_next[i], d), dsh), tele);
                if (val > top_val) val = top_val;
                diff = add_sat(diff, (val >= rank_now[i]) ? val - rank_now[i]
                                                          : rank_now[i] - val);
                rank_now[i] = val;
            end
            iters++;
            if (diff < longint'(sh_tolerance)) break;
        end
        for (int i = 0; i < n; i++)
        begin
            if (node_on[i] && rank_now[i] < best_val)
            begin
                best_val = rank_now[i];
                best = i;
            end
        end
        r.found = 1'b1;
        r.best_node = best[plsn_pkg::NODE_IDX_W-1:0];
        r.iterations_run = iters[plsn_pkg::ITER_W-1:0];
        return r;
    endfunction

    // Apply one accepted item to the shadow graph.
    function automatic void load_graph_item(cmd_item_t it);
        if (it.func == plsn_pkg::FUNC_NODE)
        begin
            if (nodes_loaded < NODE_CAP)
            begin
                row_first[nodes_loaded] = edges_loaded;
                row_degree[nodes_loaded] = 0;
                node_on[nodes_loaded] = it.node_active;
                nodes_loaded++;
                node_open = 1'b1;
            end
            else
            begin
                overflow_flag = 1'b1;
                node_open = 1'b0;
            end
        end
        else if (it.func == plsn_pkg::FUNC_EDGE)
        begin
            if (node_open)
            begin
                if (edges_loaded < EDGE_CAP)
                begin
                    nbr_mem[edges_loaded] = it.neighbor_index;
                    edges_loaded++;
                    row_degree[nodes_loaded-1]++;
                end
                else
                begin
                    overflow_flag = 1'b1;
                end
            end
        end
        else if (it.func == plsn_pkg::FUNC_START)
        begin
            expected_ranks.insert(expected_ranks.size(), rank_least_node());
        end
    endfunction

    // Item driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.func <= plsn_pkg::FUNC_NODE;
            cmd.node_active <= 1'b0;
            cmd.neighbor_index <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                load_graph_item(held_item);
                items_sent++;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    held_item = pending_items.pop_front();
                    cmd.valid <= 1'b1;
                    cmd.func <= held_item.func;
                    cmd.node_active <= held_item.node_active;
                    cmd.neighbor_index <= held_item.neighbor_index;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        rank_result_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (expected_ranks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result found=%0d best=%0d iters=%0d ovf=%0d",
                                 res.found, res.best_node, res.iterations_run,
                                 res.capacity_overflow);
                end
                else
                begin
                    want = expected_ranks.pop_front();
                    if (res.found !== want.found || res.best_node !== want.best_node
                        || res.iterations_run !== want.iterations_run
                        || res.capacity_overflow !== want.capacity_overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d expected found=%0d best=%0d ",
                                      "iters=%0d ovf=%0d, got found=%0d best=%0d iters=%0d ",
                                      "ovf=%0d"}, results_seen, want.found, want.best_node,
                                     want.iterations_run, want.capacity_overflow, res.found,
                                     res.best_node, res.iterations_run, res.capacity_overflow);
                    end
                end
            end
            res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_item(logic [plsn_pkg::FUNC_W-1:0] f, logic a, int unsigned nb);
        cmd_item_t it;
        it.func = f;
        it.node_active = a;
        it.neighbor_index = nb[plsn_pkg::NODE_IDX_W-1:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(plsn_pkg::cfg_idx_t idx, logic [plsn_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == plsn_pkg::CFG_DAMPING) sh_damping = value[plsn_pkg::DAMP_W-1:0];
        else if (idx == plsn_pkg::CFG_TOLERANCE) sh_tolerance = value[plsn_pkg::TOL_W-1:0];
        else if (idx == plsn_pkg::CFG_ITER_LIMIT) sh_iter_limit = value[plsn_pkg::ITER_W-1:0];
    endtask

    // Wait until all items are taken and every result has come back.
    task automatic drain();
        while (pending_items.size() != 0 || cmd.valid || expected_ranks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic random_settings();
        int unsigned pick;
        pick = $urandom_range(0, 2);
        write_reg(plsn_pkg::CFG_DAMPING, pick == 0 ? 32'd0 : pick == 1 ? 32'd65535
                                                                 : $urandom_range(0, 65535));
        pick = $urandom_range(0, 2);
        write_reg(plsn_pkg::CFG_TOLERANCE, pick == 0 ? 32'd0 : pick == 1 ? $urandom()
                                                         : 32'd1 << $urandom_range(0, 31));
        write_reg(plsn_pkg::CFG_ITER_LIMIT, $urandom_range(1, 6));
    endtask

    // Mostly graph building with occasional starts and some ignored codes.
    task automatic random_traffic(int unsigned count);
        int unsigned roll, starts, nodes_est;
        starts = 0;
        nodes_est = nodes_loaded;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 33)
            begin
                queue_item(plsn_pkg::FUNC_NODE, $urandom_range(0, 9) < 7, $urandom());
                nodes_est++;
            end
            else if (roll < 88)
            begin
                queue_item(plsn_pkg::FUNC_EDGE, 1'($urandom()), $urandom_range(0, 9) < 8
                           ? $urandom_range(0, nodes_est + 1) : $urandom_range(0, 1023));
            end
            else if (roll < 94)
            begin
                queue_item(plsn_pkg::FUNC_START, 1'($urandom()), $urandom());
                starts++;
            end
            else
            begin
                queue_item(FUNC_UNUSED, 1'($urandom()), $urandom());
            end
        end
        while (starts < 12)
        begin
            queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
            starts++;
        end
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = plsn_pkg::CFG_DAMPING;
        cfg.data = '0;
        sh_damping = plsn_pkg::DAMP_RESET;
        sh_tolerance = plsn_pkg::TOL_RESET;
        sh_iter_limit = plsn_pkg::ITER_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty graph, ignored items, inactive-only graph, ties, dead edges.
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        queue_item(plsn_pkg::FUNC_EDGE, 1'b1, 1023);
        queue_item(FUNC_UNUSED, 1'b1, 1023);
        queue_item(plsn_pkg::FUNC_NODE, 1'b0, 0);
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        queue_item(plsn_pkg::FUNC_NODE, 1'b1, 0);
        queue_item(plsn_pkg::FUNC_EDGE, 1'b0, 1);
        queue_item(plsn_pkg::FUNC_EDGE, 1'b0, 1023);
        queue_item(plsn_pkg::FUNC_EDGE, 1'b0, 0);
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        queue_item(plsn_pkg::FUNC_NODE, 1'b1, 0);
        queue_item(plsn_pkg::FUNC_NODE, 1'b1, 0);
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        drain();
        write_reg(plsn_pkg::CFG_DAMPING, 32'd0);
        write_reg(plsn_pkg::CFG_TOLERANCE, 32'd0);
        write_reg(plsn_pkg::CFG_ITER_LIMIT, 32'd1);
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        drain();
        write_reg(plsn_pkg::CFG_DAMPING, 32'd65535);
        write_reg(plsn_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(plsn_pkg::CFG_ITER_LIMIT, 32'd4095);
        queue_item(plsn_pkg::FUNC_START, 1'b0, 0);
        drain();

        // Random phases with different back-pressure.
        random_settings();
        send_idle_pct = 31;
        recv_idle_pct = 77;
        random_traffic(210);
        drain();
        random_settings();
        send_idle_pct = 77;
        recv_idle_pct = 31;
        random_traffic(210);
        drain();
        random_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(210);
        drain();

        $display("Run covered %0d items and %0d results over three back-pressure mixes,",
                 items_sent, results_seen);
        $display("including empty and inactive-only graphs, ties and edges to absent nodes.");
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d mismatching results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
